// File: hdl/rllt_pkg.sv
// ============================================================================
// rllt_pkg
// Shared types and constants for the run-length line table.
// ============================================================================
package rllt_pkg;

    localparam int MAX_RUNS       = 1024;
    localparam int MAX_CODE_BYTES = 65536;

    localparam int LINE_W  = 20;
    localparam int OFF_W   = 16;
    localparam int LEN_W   = $clog2(MAX_CODE_BYTES) + 1;
    localparam int IDX_W   = $clog2(MAX_RUNS);
    localparam int COUNT_W = $clog2(MAX_RUNS) + 1;
    localparam int SUM_W   = $clog2(MAX_RUNS) + $clog2(MAX_CODE_BYTES) + 1;
    localparam int ENTRY_W = LINE_W + LEN_W;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

endpackage

// File: hdl/run_length_line_table.sv
// ============================================================================
// run_length_line_table
// Run-length encoded table of source line numbers per code byte.
// ============================================================================
// Append: result strobe in the cycle after the transfer; busy stays low.
// Lookup: one RAM read per run, pipelined through the single read port of the
//   run RAM; the result strobes once the running sum of run lengths passes the
//   offset (hit) or after the last run is read (miss), with busy high meanwhile.
// Lookup on an empty table: strobe in the next cycle.
// Reset empties the table at once; the RAM contents are not cleared.
module run_length_line_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         req_type,
    input  logic [rllt_pkg::LINE_W-1:0]  line,
    input  logic [rllt_pkg::OFF_W-1:0]   offset,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [rllt_pkg::LINE_W-1:0]  found_line
);

    localparam int LINE_W  = rllt_pkg::LINE_W;
    localparam int OFF_W   = rllt_pkg::OFF_W;
    localparam int LEN_W   = rllt_pkg::LEN_W;
    localparam int IDX_W   = rllt_pkg::IDX_W;
    localparam int COUNT_W = rllt_pkg::COUNT_W;
    localparam int SUM_W   = rllt_pkg::SUM_W;
    localparam int ENTRY_W = rllt_pkg::ENTRY_W;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t                    state_reg,     state_next;
    logic [COUNT_W-1:0]        count_reg,     count_next;
    logic [COUNT_W-1:0]        rd_cnt_reg,    rd_cnt_next;
    logic                      pend_reg,      pend_next;
    logic                      last_iss_reg,  last_iss_next;
    logic                      done_reg,      done_next;
    rllt_pkg::status_t         status_reg,    status_next;
    logic [LINE_W-1:0]         found_reg,     found_next;
    logic [LINE_W-1:0]         last_line_reg, last_line_next;
    logic [LEN_W-1:0]          last_len_reg,  last_len_next;
    logic [SUM_W-1:0]          sum_reg,       sum_next;
    logic [OFF_W-1:0]          off_reg,       off_next;

    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [ENTRY_W-1:0]        wr_data;
    logic                      rd_en;
    logic [ENTRY_W-1:0]        rd_data;
    logic [LINE_W-1:0]         rd_line;
    logic [LEN_W-1:0]          rd_len;
    logic [COUNT_W-1:0]        last_idx_full;
    logic [COUNT_W-1:0]        rd_cnt_inc;
    logic [LEN_W-1:0]          last_len_inc;
    logic [SUM_W-1:0]          walk_sum;

    rllt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (rllt_pkg::MAX_RUNS)
    ) u_run_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign rd_line       = rd_data[ENTRY_W-1:LEN_W];
    assign rd_len        = rd_data[LEN_W-1:0];
    assign last_idx_full = count_reg - COUNT_W'(1);
    assign rd_cnt_inc    = rd_cnt_reg + COUNT_W'(1);
    assign last_len_inc  = last_len_reg + LEN_W'(1);
    assign walk_sum      = sum_reg + SUM_W'(rd_len);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        last_iss_next  = 1'b0;
        done_next      = 1'b0;
        status_next    = status_reg;
        found_next     = found_reg;
        last_line_next = last_line_reg;
        last_len_next  = last_len_reg;
        sum_next       = sum_reg;
        off_next       = off_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = {line, LEN_W'(1)};
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == rllt_pkg::REQ_APPEND)
                    begin
                        done_next   = 1'b1;
                        status_next = rllt_pkg::ST_OK;
                        found_next  = '0;
                        if (count_reg != '0 && last_line_reg == line)
                        begin
                            if (last_len_reg < LEN_W'(rllt_pkg::MAX_CODE_BYTES))
                            begin
                                last_len_next = last_len_inc;
                                wr_en         = 1'b1;
                                wr_addr       = last_idx_full[IDX_W-1:0];
                                wr_data       = {line, last_len_inc};
                            end
                        end
                        else if (count_reg == COUNT_W'(rllt_pkg::MAX_RUNS))
                        begin
                            status_next = rllt_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en          = 1'b1;
                            last_line_next = line;
                            last_len_next  = LEN_W'(1);
                            count_next     = count_reg + COUNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = rllt_pkg::ST_NOT_FOUND;
                        found_next  = '0;
                    end
                    else
                    begin
                        state_next  = S_WALK;
                        rd_cnt_next = '0;
                        sum_next    = '0;
                        off_next    = offset;
                    end
                end
            end

            S_WALK:
            begin
                // issue the next run read
                if (rd_cnt_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_cnt_next   = rd_cnt_inc;
                    pend_next     = 1'b1;
                    last_iss_next = (rd_cnt_inc == count_reg);
                end
                // accumulate the run read last cycle
                if (pend_reg)
                begin
                    sum_next = walk_sum;
                    if (walk_sum > SUM_W'(off_reg))
                    begin
                        done_next   = 1'b1;
                        status_next = rllt_pkg::ST_OK;
                        found_next  = rd_line;
                        state_next  = S_IDLE;
                        pend_next   = 1'b0;
                    end
                    else if (last_iss_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = rllt_pkg::ST_NOT_FOUND;
                        found_next  = '0;
                        state_next  = S_IDLE;
                        pend_next   = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_cnt_reg   <= '0;
            pend_reg     <= 1'b0;
            last_iss_reg <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= rllt_pkg::ST_OK;
            found_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_cnt_reg   <= rd_cnt_next;
            pend_reg     <= pend_next;
            last_iss_reg <= last_iss_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_line_reg <= last_line_next;
        last_len_reg  <= last_len_next;
        sum_reg       <= sum_next;
        off_reg       <= off_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign found_line = found_reg;

endmodule

// File: hdl/rllt_ram.sv
// ============================================================================
// rllt_ram
// Generic single-clock RAM, one write port, one registered read port.
// ============================================================================
module rllt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/rllt_checker.sv
// ============================================================================
// rllt_checker
// Port-level checks for the run-length line table, bound to the top level.
// ============================================================================
module rllt_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         req_type,
    input  logic                         done,
    input  logic [1:0]                   status,
    input  logic [rllt_pkg::LINE_W-1:0]  found_line
);

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == rllt_pkg::REQ_APPEND |=> done && !busy)
    else $error("append transfer not answered in the next cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == rllt_pkg::REQ_LOOKUP |=> busy || done)
    else $error("lookup transfer neither started a walk nor answered");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && status != rllt_pkg::ST_OK |-> found_line == '0)
    else $error("found_line nonzero on a failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && status == rllt_pkg::ST_FULL |->
            $past(start && !busy && req_type == rllt_pkg::REQ_APPEND))
    else $error("table full reported for something other than an append");

endmodule

bind run_length_line_table rllt_checker u_rllt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .done       (done),
    .status     (status),
    .found_line (found_line)
);

// File: verif/run_length_line_table_tb.sv
// ============================================================================
// run_length_line_table_tb
// Self-checking bench for the run-length line table. A short directed table
// covers the empty table, the field extremes and the ends of the stored runs.
// Three random phases with different sender gaps follow.
// Results are checked against typed row values or an in-bench prediction.
// ============================================================================
`timescale 1ns / 100ps

module run_length_line_table_tb;

    localparam int LINE_W         = rllt_pkg::LINE_W;
    localparam int OFF_W          = rllt_pkg::OFF_W;
    localparam int LEN_W          = rllt_pkg::LEN_W;
    localparam int MAX_RUNS       = rllt_pkg::MAX_RUNS;
    localparam int MAX_CODE_BYTES = rllt_pkg::MAX_CODE_BYTES;

    localparam logic REQ_APPEND = rllt_pkg::REQ_APPEND;
    localparam logic REQ_LOOKUP = rllt_pkg::REQ_LOOKUP;

    typedef rllt_pkg::status_t status_t;

    localparam status_t ST_OK        = rllt_pkg::ST_OK;
    localparam status_t ST_NOT_FOUND = rllt_pkg::ST_NOT_FOUND;

    typedef struct packed {
        logic              rq;
        logic [LINE_W-1:0] ln;
        logic [OFF_W-1:0]  of;
        logic              typed;
        status_t           st;
        logic [LINE_W-1:0] fl;
    } dir_row_t;

    typedef struct {
        status_t           st;
        logic [LINE_W-1:0] ln;
    } outcome_t;

    localparam int N_DIRECTED = 18;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{REQ_LOOKUP, 20'hFFFFF, 16'h0000, 1'b1, ST_NOT_FOUND, 20'h00000},
        '{REQ_APPEND, 20'h00000, 16'hFFFF, 1'b1, ST_OK,        20'h00000},
        '{REQ_APPEND, 20'hFFFFF, 16'h0000, 1'b1, ST_OK,        20'h00000},
        '{REQ_APPEND, 20'hFFFFF, 16'h5555, 1'b1, ST_OK,        20'h00000},
        '{REQ_APPEND, 20'hAAAAA, 16'hAAAA, 1'b0, ST_OK,        20'h00000},
        '{REQ_APPEND, 20'h55555, 16'h0000, 1'b0, ST_OK,        20'h00000},
        '{REQ_APPEND, 20'h55555, 16'h0000, 1'b0, ST_OK,        20'h00000},
        '{REQ_LOOKUP, 20'h00000, 16'h0000, 1'b1, ST_OK,        20'h00000},
        '{REQ_LOOKUP, 20'hAAAAA, 16'h0001, 1'b1, ST_OK,        20'hFFFFF},
        '{REQ_LOOKUP, 20'h00000, 16'h0002, 1'b0, ST_OK,        20'h00000},
        '{REQ_LOOKUP, 20'h00000, 16'h0003, 1'b0, ST_OK,        20'h00000},
        '{REQ_LOOKUP, 20'h55555, 16'h0004, 1'b0, ST_OK,        20'h00000},
        '{REQ_LOOKUP, 20'h00000, 16'h0005, 1'b1, ST_OK,        20'h55555},
        '{REQ_LOOKUP, 20'h00000, 16'h0006, 1'b1, ST_NOT_FOUND, 20'h00000},
        '{REQ_LOOKUP, 20'h00000, 16'hFFFF, 1'b1, ST_NOT_FOUND, 20'h00000},
        '{REQ_LOOKUP, 20'h00000, 16'h5555, 1'b1, ST_NOT_FOUND, 20'h00000},
        '{REQ_APPEND, 20'h00000, 16'hAAAA, 1'b0, ST_OK,        20'h00000},
        '{REQ_LOOKUP, 20'h12345, 16'h0006, 1'b0, ST_OK,        20'h00000}
    };

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              start      = 1'b0;
    logic              req_type   = REQ_APPEND;
    logic [LINE_W-1:0] line       = '0;
    logic [OFF_W-1:0]  offset     = '0;
    logic              busy;
    logic              done;
    logic [1:0]        status;
    logic [LINE_W-1:0] found_line;

    logic [LINE_W-1:0] run_ln  [MAX_RUNS];
    logic [LEN_W-1:0]  run_len [MAX_RUNS];
    int                runs_held  = 0;
    longint            bytes_held = 0;

    outcome_t awaited[$];
    int       mismatches = 0;
    int       idle_pct   = 0;

    run_length_line_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .line       (line),
        .offset     (offset),
        .done       (done),
        .status     (status),
        .found_line (found_line)
    );

    always #1 clk = ~clk;

    function automatic void line_table_step(input logic rq, input logic [LINE_W-1:0] ln,
                                            input logic [OFF_W-1:0] of,
                                            output status_t st,
                                            output logic [LINE_W-1:0] fl);
        longint acc;
        bit     hit;
        st  = ST_OK;
        fl  = '0;
        acc = 0;
        hit = 1'b0;
        if (rq == REQ_APPEND)
        begin
            if (runs_held > 0 && run_ln[runs_held-1] == ln)
            begin
                if (run_len[runs_held-1] < MAX_CODE_BYTES)
                begin
                    run_len[runs_held-1] = run_len[runs_held-1] + 1'b1;
                    bytes_held++;
                end
            end
            else if (runs_held >= MAX_RUNS)
            begin
                st = rllt_pkg::ST_FULL;
            end
            else
            begin
                run_ln[runs_held]  = ln;
                run_len[runs_held] = LEN_W'(1);
                runs_held++;
                bytes_held++;
            end
        end
        else
        begin
            st = ST_NOT_FOUND;
            for (int k = 0; k < runs_held && !hit; k++)
            begin
                acc += run_len[k];
                if (acc > of)
                begin
                    hit = 1'b1;
                    st  = ST_OK;
                    fl  = run_ln[k];
                end
            end
        end
    endfunction

    function automatic logic [LINE_W-1:0] fresh_line();
        logic [LINE_W-1:0] v;
        v = ($urandom_range(0, 1) == 0) ? LINE_W'($urandom_range(0, 31)) : LINE_W'($urandom);
        if (runs_held > 0 && v == run_ln[runs_held-1])
            v = v ^ 1'b1;
        return v;
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset();
        int unsigned hi;
        hi = (bytes_held > 65535) ? 65535 : int'(bytes_held);
        if ($urandom_range(0, 99) < 80)
            return OFF_W'($urandom_range(0, hi));
        return OFF_W'($urandom);
    endfunction

    task automatic issue(input logic rq, input logic [LINE_W-1:0] ln,
                         input logic [OFF_W-1:0] of, input bit typed,
                         input status_t t_st, input logic [LINE_W-1:0] t_ln);
        outcome_t want;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= rq;
        line     <= ln;
        offset   <= of;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        line_table_step(rq, ln, of, want.st, want.ln);
        if (typed)
        begin
            want.st = t_st;
            want.ln = t_ln;
        end
        awaited.push_back(want);
    endtask

    task automatic random_traffic(input int count, input int gap_pct);
        idle_pct = gap_pct;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 62)
            begin
                if (runs_held > 0 && $urandom_range(0, 99) < 55)
                    issue(REQ_APPEND, run_ln[runs_held-1], OFF_W'($urandom), 1'b0, ST_OK, '0);
                else
                    issue(REQ_APPEND, fresh_line(), OFF_W'($urandom), 1'b0, ST_OK, '0);
            end
            else
            begin
                issue(REQ_LOOKUP, LINE_W'($urandom), pick_offset(), 1'b0, ST_OK, '0);
            end
        end
    endtask

    // check each result strobe against the oldest pending transfer
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (awaited.size() == 0)
            begin
                $display("%0t unexpected result: status %0d found_line %h",
                         $time, status, found_line);
                mismatches++;
            end
            else
            begin
                want = awaited.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.st, status);
                    mismatches++;
                end
                if (found_line !== want.ln)
                begin
                    $display("%0t found_line mismatch: expected %h actual %h",
                             $time, want.ln, found_line);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #6_000_000;
        $display("FAIL run_length_line_table");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 10;
        for (int i = 0; i < N_DIRECTED; i++)
            issue(DIRECTED[i].rq, DIRECTED[i].ln, DIRECTED[i].of,
                  DIRECTED[i].typed, DIRECTED[i].st, DIRECTED[i].fl);

        random_traffic(187, 10);
        random_traffic(187, 70);
        random_traffic(187, 0);

        start <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (MAX_RUNS + 8) @(posedge clk);

        if (mismatches == 0)
            $display("PASS run_length_line_table");
        else
            $display("FAIL run_length_line_table");
        $finish;
    end

endmodule
